>>> design/spks_pkg.sv
// Shared types, constants and elaboration helpers for the phone key sorter.
`timescale 1ns / 1ps
`default_nettype none
package spks_pkg;

    localparam int KEY_W    = 50;
    localparam int TAG_W    = 16;
    localparam int DATA_W   = 72;
    localparam int DIGIT_BASE = 10;

    typedef struct packed {
        logic [KEY_W-1:0] rank;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             done;
        logic [KEY_W-1:0] rank;
    } mod_rsp_t;

    function automatic logic [63:0] pow10(input int digits);
        logic [63:0] m;
        m = 64'd1;
        for (int d = 0; d < digits && d < 19; d++) begin
            m = m * 64'(DIGIT_BASE);
        end
        return m;
    endfunction

    function automatic int bit_len(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> design/spks_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module spks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> design/spks_mod.sv
// Iterative reduction of a key modulo 10^KEY_DIGITS, one conditional subtract per cycle.
`timescale 1ns / 1ps
`default_nettype none
module spks_mod #(
    parameter int KEY_DIGITS = 15
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [spks_pkg::KEY_W-1:0]  key_in,
    output spks_pkg::mod_rsp_t               rsp
);

    localparam int KW_ = spks_pkg::KEY_W;
    localparam logic [63:0] MOD_VAL = spks_pkg::pow10(KEY_DIGITS);
    localparam int MOD_BITS = spks_pkg::bit_len(MOD_VAL);
    localparam bit IDENT = (MOD_BITS > KW_);
    localparam int SHIFTS = IDENT ? 0 : KW_ - MOD_BITS;
    localparam int CNT_W = (SHIFTS > 0) ? $clog2(SHIFTS + 1) : 1;
    localparam logic [63:0] D_WIDE = MOD_VAL << SHIFTS;
    localparam logic [KW_-1:0] D_INIT = D_WIDE[KW_-1:0];

    logic [KW_-1:0]   r_reg, r_next;
    logic [KW_-1:0]   d_reg, d_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb begin
        r_next    = r_reg;
        d_next    = d_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            r_next = key_in;
            d_next = D_INIT;
            k_next = CNT_W'(SHIFTS);
            if (IDENT) begin
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (r_reg >= d_reg) begin
                r_next = r_reg - d_reg;
            end
            d_next = d_reg >> 1;
            if (k_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        r_reg <= r_next;
        d_reg <= d_next;
        k_reg <= k_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rank = r_reg;

endmodule
`default_nettype wire

>>> design/stable_phone_key_sorter_top.sv
// Top level of the stable phone key sorter: load, sorted insert and ordered emit.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: phone_key, record_tag; s_tlast: last_record
//  m_      | out | m_tvalid/m_tready  | m_tdata: sorted_key, sorted_tag; m_tlast; m_tuser
//
// A stored record is reduced in S_MOD by spks_mod, which skips the subtract steps when
// 10^KEY_DIGITS exceeds 2^50, then inserted in S_INS, which shifts larger entries up in the
// record RAM; S_PUT writes it at address 0 when every entry was shifted or none is held.
// An overflowed record is not stored and only sets the drop flag. A run does one RAM read in
// S_RD, then per result loads the output register in S_CAP and waits for the transfer in S_OUT.
// Reset empties the set; the RAM is not cleared. m_tready low holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module stable_phone_key_sorter_top #(
    parameter int MAX_RECORDS = 64,
    parameter int KEY_DIGITS  = 15
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [spks_pkg::DATA_W-1:0]  s_tdata,  // phone_key[49:0], record_tag[65:50]
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [spks_pkg::DATA_W-1:0]  m_tdata,  // sorted_key[49:0], sorted_tag[65:50]
    output logic                              m_tlast,
    output logic                              m_tuser   // dropped_any
);

    localparam int KEY_W = spks_pkg::KEY_W;
    localparam int TAG_W = spks_pkg::TAG_W;
    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_INS, S_PUT, S_RD, S_CAP, S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic             last_reg, last_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [AW-1:0]    e_reg, e_next;
    logic             m_valid_reg, m_valid_next;
    logic [KEY_W-1:0] m_key_reg, m_key_next;
    logic [TAG_W-1:0] m_tag_reg, m_tag_next;
    logic             m_last_reg, m_last_next;
    logic             m_drop_reg, m_drop_next;

    logic                    mod_start;
    spks_pkg::mod_rsp_t      mod_rsp;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    spks_pkg::entry_t        wr_ent;
    logic [AW-1:0]           rd_addr;
    logic [spks_pkg::ENTRY_W-1:0] rd_data;
    spks_pkg::entry_t        rd_ent;
    spks_pkg::entry_t        new_ent;
    logic                    s_xfer;

    assign rd_ent   = rd_data;
    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    assign new_ent.rank = mod_rsp.rank;
    assign new_ent.key  = key_reg;
    assign new_ent.tag  = tag_reg;

    spks_mod #(
        .KEY_DIGITS(KEY_DIGITS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .key_in  (s_tdata[KEY_W-1:0]),
        .rsp     (mod_rsp)
    );

    spks_ram #(
        .WIDTH(spks_pkg::ENTRY_W),
        .DEPTH(MAX_RECORDS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        key_next     = key_reg;
        tag_next     = tag_reg;
        last_next    = last_reg;
        j_next       = j_reg;
        e_next       = e_reg;
        m_valid_next = m_valid_reg;
        m_key_next   = m_key_reg;
        m_tag_next   = m_tag_reg;
        m_last_next  = m_last_reg;
        m_drop_next  = m_drop_reg;
        mod_start    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = j_reg;
        wr_ent       = new_ent;
        rd_addr      = e_reg + 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    last_next = s_tlast;
                    if (count_reg != CW'(MAX_RECORDS)) begin
                        key_next   = s_tdata[KEY_W-1:0];
                        tag_next   = s_tdata[KEY_W+TAG_W-1:KEY_W];
                        state_next = S_MOD;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_tlast) begin
                            e_next     = '0;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    if (count_reg == '0) begin
                        j_next     = '0;
                        state_next = S_PUT;
                    end else begin
                        rd_addr    = AW'(count_reg - 1'b1);
                        j_next     = AW'(count_reg);
                        state_next = S_INS;
                    end
                end
            end
            S_INS: begin
                wr_en = 1'b1;
                if (rd_ent.rank > mod_rsp.rank) begin
                    wr_ent = rd_ent;
                    j_next = j_reg - 1'b1;
                    if (j_reg == AW'(1)) begin
                        state_next = S_PUT;
                    end else begin
                        rd_addr = j_reg - AW'(2);
                    end
                end else begin
                    count_next = count_reg + 1'b1;
                    e_next     = '0;
                    state_next = last_reg ? S_RD : S_IDLE;
                end
            end
            S_PUT: begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                e_next     = '0;
                state_next = last_reg ? S_RD : S_IDLE;
            end
            S_RD: begin
                rd_addr    = e_reg;
                state_next = S_CAP;
            end
            S_CAP: begin
                m_valid_next = 1'b1;
                m_key_next   = rd_ent.key;
                m_tag_next   = rd_ent.tag;
                m_last_next  = (CW'(e_reg) + 1'b1 == count_reg);
                m_drop_next  = (CW'(e_reg) + 1'b1 == count_reg) && ovf_reg;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        e_next     = e_reg + 1'b1;
                        state_next = S_CAP;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_IDLE && s_xfer && count_reg != CW'(MAX_RECORDS)) begin
            mod_start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg    <= key_next;
        tag_reg    <= tag_next;
        last_reg   <= last_next;
        j_reg      <= j_next;
        e_reg      <= e_next;
        m_key_reg  <= m_key_next;
        m_tag_reg  <= m_tag_next;
        m_last_reg <= m_last_next;
        m_drop_reg <= m_drop_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(spks_pkg::DATA_W - KEY_W - TAG_W){1'b0}}, m_tag_reg, m_key_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_drop_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CW'(MAX_RECORDS))
        else $error("record count above capacity");
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid && m_tuser |-> m_tlast)
        else $error("drop flag on a result that is not last");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> count_reg == '0 && !ovf_reg)
        else $error("set not cleared after final transfer");

endmodule
`default_nettype wire

>>> tb/stable_phone_key_sorter_top_tb.sv
// Self-checking testbench for the stable phone key sorter: directed and random record sets.
`timescale 1ns / 1ps
module stable_phone_key_sorter_top_tb;

    localparam int KEY_W  = spks_pkg::KEY_W;
    localparam int TAG_W  = spks_pkg::TAG_W;
    localparam int DATA_W = spks_pkg::DATA_W;

    localparam int MAX_RECORDS = 64;
    localparam int KEY_DIGITS  = 15;
    localparam logic [63:0] DIGIT_MOD = spks_pkg::pow10(KEY_DIGITS);
    localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             drop;
    } sorted_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             typed;
        sorted_item_t     res;
    } plan_row_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // phone_key[49:0], record_tag[65:50]
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // sorted_key[49:0], sorted_tag[65:50]
    logic              m_tlast;
    logic              m_tuser;         // dropped_any

    stable_phone_key_sorter_top #(
        .MAX_RECORDS(MAX_RECORDS),
        .KEY_DIGITS (KEY_DIGITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    // predictor state: records of the set being loaded
    logic [KEY_W-1:0] set_keys [MAX_RECORDS];
    logic [TAG_W-1:0] set_tags [MAX_RECORDS];
    int               set_count   = 0;
    bit               set_dropped = 1'b0;

    sorted_item_t sorted_out [$];
    sorted_item_t sorted_due [$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    bit hold_go           = 1'b0;
    bit hold_done         = 1'b0;
    int hold_count        = 0;

    int mismatch_count = 0;
    int records_sent   = 0;
    int sets_sent      = 0;
    int drop_sets      = 0;
    int results_seen   = 0;

    plan_row_t plan [13] = '{
        '{50'd0,                16'h0000, 1'b1, 1'b1, '{50'd0, 16'h0000, 1'b1, 1'b0}},
        '{KEY_TOP,              16'hFFFF, 1'b1, 1'b1, '{KEY_TOP, 16'hFFFF, 1'b1, 1'b0}},
        '{50'd999999999999999,  16'h0001, 1'b0, 1'b0, '0},
        '{50'd1000000000000000, 16'h0002, 1'b0, 1'b0, '0},
        '{50'd5,                16'h0003, 1'b0, 1'b0, '0},
        '{50'd1000000000000005, 16'h0004, 1'b0, 1'b0, '0},
        '{50'd0,                16'h0005, 1'b0, 1'b0, '0},
        '{50'd5,                16'h0006, 1'b1, 1'b0, '0},
        '{50'd42,               16'hAAAA, 1'b0, 1'b0, '0},
        '{50'd42,               16'h5555, 1'b0, 1'b0, '0},
        '{50'd42,               16'h1234, 1'b1, 1'b0, '0},
        '{50'd7,                16'h0007, 1'b0, 1'b0, '0},
        '{50'd3,                16'h0008, 1'b1, 1'b0, '0}
    };

    initial begin
        forever #4 aclk = ~aclk;
    end

    // file one record; on the last one, produce the stable order by key modulo 10^15
    function automatic void load_and_sort(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                          bit last);
        int           order [MAX_RECORDS];
        logic [63:0]  rank_of [MAX_RECORDS];
        int           cur;
        int           j;
        sorted_item_t item;
        sorted_out.delete();
        if (set_count < MAX_RECORDS) begin
            set_keys[set_count] = key;
            set_tags[set_count] = tag;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!last) return;
        for (int i = 0; i < set_count; i++) begin
            order[i]   = i;
            rank_of[i] = {14'd0, set_keys[i]} % DIGIT_MOD;
        end
        for (int i = 1; i < set_count; i++) begin
            cur = order[i];
            j   = i;
            while (j > 0 && rank_of[order[j-1]] > rank_of[cur]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        for (int i = 0; i < set_count; i++) begin
            item.key  = set_keys[order[i]];
            item.tag  = set_tags[order[i]];
            item.last = (i == set_count - 1);
            item.drop = item.last && set_dropped;
            sorted_out = {sorted_out, item};
        end
        if (set_dropped) drop_sets++;
        set_count   = 0;
        set_dropped = 1'b0;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return raw[KEY_W-1:0];
            1: return KEY_W'({14'd0, raw[KEY_W-1:0]} % DIGIT_MOD);
            2: return KEY_W'($urandom_range(0, 7));
            default: return KEY_W'(DIGIT_MOD + 64'($urandom_range(0, 7)));
        endcase
    endfunction

    task automatic send_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, bit last,
                               bit typed, sorted_item_t typed_res);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - KEY_W - TAG_W){1'b0}}, tag, key};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        load_and_sort(key, tag, last);
        if (typed) begin
            sorted_due = {sorted_due, typed_res};
        end else begin
            sorted_due = {sorted_due, sorted_out};
        end
        records_sent++;
        if (last) sets_sent++;
    endtask

    task automatic send_set(int size);
        for (int k = 0; k < size; k++) begin
            send_record(pick_key(), TAG_W'($urandom_range(0, 65535)), k == size - 1, 1'b0, '0);
        end
    endtask

    // hold the sender until every expected result has been seen
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sorted_due.size() != 0);
    endtask

    task automatic run_phase(int goal, int big_size, bit with_hold);
        int start;
        start = records_sent;
        send_set(big_size);
        if (with_hold) hold_go <= 1'b1;
        while (records_sent - start < goal) begin
            if ($urandom_range(0, 7) == 0) send_set($urandom_range(11, 40));
            else send_set($urandom_range(1, 10));
        end
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        sorted_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (sorted_due.size() == 0) begin
                $error("unexpected result: key %h tag %h", m_tdata[KEY_W-1:0],
                       m_tdata[KEY_W+TAG_W-1:KEY_W]);
                mismatch_count++;
            end else begin
                want = sorted_due.pop_front();
                if (m_tdata[KEY_W-1:0] !== want.key) begin
                    $error("sorted_key: expected %h, got %h", want.key, m_tdata[KEY_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[KEY_W+TAG_W-1:KEY_W] !== want.tag) begin
                    $error("sorted_tag: expected %h, got %h", want.tag,
                           m_tdata[KEY_W+TAG_W-1:KEY_W]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_out: expected %b, got %b", want.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== want.drop) begin
                    $error("dropped_any: expected %b, got %b", want.drop, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[r]) begin
            send_record(plan[r].key, plan[r].tag, plan[r].last, plan[r].typed, plan[r].res);
        end
        drain_results();

        sender_idle_pct   = 33;
        receiver_idle_pct <= 60;
        run_phase(115, MAX_RECORDS + 1, 1'b1);

        sender_idle_pct   = 60;
        receiver_idle_pct <= 33;
        run_phase(115, MAX_RECORDS + 4, 1'b0);

        sender_idle_pct   = 0;
        receiver_idle_pct <= 0;
        run_phase(115, MAX_RECORDS, 1'b0);

        repeat (200) @(posedge aclk);
        if (sorted_due.size() != 0) begin
            $error("%0d expected results never arrived", sorted_due.size());
            mismatch_count++;
        end
        $display("Sent %0d records in %0d sets (%0d with records dropped at capacity)",
                 records_sent, sets_sent, drop_sets);
        $display("Checked %0d sorted results, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
